// ----- rtl/core/command_line_tokenizer_macros.svh -----
// Assertion macros for the command line tokenizer checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Clocked assertion, masked while reset is held.
`define CLT_ASSERT(lbl, prp) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prp)) \
    else $error("command_line_tokenizer assertion failed");

// Same, with a message of the caller's choosing.
`define CLT_ASSERT_MSG(lbl, prp, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prp)) \
    else $error(msg);

`endif

// ----- rtl/core/clt_pkg.sv -----
// Shared types and constants of the command line tokenizer.
// No dependencies.
package clt_pkg;

  localparam logic [1:0] MODE_COMMAND = 2'd0;
  localparam logic [1:0] MODE_ARG1    = 2'd1;
  localparam logic [1:0] MODE_ARG2    = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TILDE = 8'h7E;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;

  localparam logic [7:0] REG_COMMAND_MAX_LEN  = 8'd0;
  localparam logic [7:0] REG_ARGUMENT_MAX_LEN = 8'd1;

  localparam logic [7:0] COMMAND_MAX_LEN_RST  = 8'd4;
  localparam logic [7:0] ARGUMENT_MAX_LEN_RST = 8'd40;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic       cr_seen;
    logic [7:0] fill;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic       kind;
    logic [1:0] field_id;
    logic [7:0] char_pos;
    logic [7:0] char_value;
    logic       line_valid;
  } parse_result_t;

endpackage

// ----- rtl/core/clt_parse.sv -----
// Combinational byte parser: next parse state and optional result for one byte.
// Depends on clt_pkg.
module clt_parse (
  input  logic [7:0]             byte_in,
  input  logic [7:0]             command_max_len,
  input  logic [7:0]             argument_max_len,
  input  clt_pkg::parse_state_t  state_cur,
  output clt_pkg::parse_state_t  state_nxt,
  output clt_pkg::parse_result_t result
);

  logic [7:0] limit;
  logic       discard;

  assign limit = (state_cur.mode == clt_pkg::MODE_COMMAND) ? command_max_len
                                                            : argument_max_len;

  always_comb begin
    state_nxt = state_cur;
    result    = '0;
    discard   = 1'b0;
    if (state_cur.mode == clt_pkg::MODE_INVALID) begin
      discard = 1'b1;
    end else if (state_cur.cr_seen) begin
      if (byte_in == clt_pkg::BYTE_LF) begin
        state_nxt         = '0;
        result.emit       = 1'b1;
        result.kind       = clt_pkg::KIND_EOL;
        result.line_valid = 1'b1;
      end else begin
        state_nxt.mode = clt_pkg::MODE_INVALID;
        discard        = 1'b1;
      end
    end else if (byte_in == clt_pkg::BYTE_SPACE) begin
      state_nxt.mode = (state_cur.mode == clt_pkg::MODE_ARG2) ? clt_pkg::MODE_INVALID
                                                              : state_cur.mode + 2'd1;
      state_nxt.fill = '0;
    end else if (byte_in == clt_pkg::BYTE_CR) begin
      state_nxt.cr_seen = 1'b1;
    end else if (state_cur.fill >= limit || byte_in < clt_pkg::BYTE_SPACE ||
                 byte_in > clt_pkg::BYTE_TILDE) begin
      state_nxt.mode    = clt_pkg::MODE_INVALID;
      state_nxt.cr_seen = 1'b0;
    end else begin
      result.emit       = 1'b1;
      result.kind       = clt_pkg::KIND_CHAR;
      result.field_id   = state_cur.mode;
      result.char_pos   = state_cur.fill;
      result.char_value = byte_in;
      state_nxt.fill    = state_cur.fill + 8'd1;
    end

    // Invalid line: drop bytes, watch for CR LF.
    if (discard) begin
      if (byte_in == clt_pkg::BYTE_CR) begin
        state_nxt.cr_seen = 1'b1;
      end else if (byte_in == clt_pkg::BYTE_LF && state_cur.cr_seen) begin
        state_nxt   = '0;
        result.emit = 1'b1;
        result.kind = clt_pkg::KIND_EOL;
      end else begin
        state_nxt.cr_seen = 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/command_line_tokenizer.sv -----
// Top level of the command line tokenizer: input register, parse state,
// length registers and result register. Depends on clt_pkg and clt_parse.
//
// Usage:
//   Input channel (in_valid, in_stall, in_byte): one received byte per
//   transfer. Result channel (out_valid, out_stall, out_*): one result per
//   transfer, either a field character (kind 0, with field and position) or
//   an end of line marker (kind 1, with line_valid). Many bytes give no
//   result (spaces, CR, dropped bytes).
//   Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 sets
//   the command word length limit, index 1 the argument length limit; other
//   indexes are ignored. cfg_ready is always high. Write only while idle.
//   A byte taken from the input channel waits in the input register, is
//   parsed into the result register and offered from there.
//   Throughput: one byte per cycle unless out_stall holds a result, set by
//   the single parse step between the input and result registers.
//   Stall: while a result waits under out_stall, the byte held in the input
//   register waits too and in_stall rises; nothing is lost or reordered.
//   Reset (synchronous, rst_n low): both registers empty, parser in command
//   word mode, limits back to 4 and 40.
module command_line_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_result_kind,
  output logic [1:0] out_field_id,
  output logic [7:0] out_char_pos,
  output logic [7:0] out_char_value,
  output logic       out_line_valid,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic [7:0]             cmd_max_r;
  logic [7:0]             arg_max_r;
  clt_pkg::parse_state_t  state_r;
  clt_pkg::parse_state_t  state_nxt;
  clt_pkg::parse_result_t res;
  clt_pkg::parse_result_t out_r;
  logic                   out_valid_r;
  logic                   advance;

  // Advance the held byte whenever the result register is free or draining.
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign cfg_ready = 1'b1;

  clt_parse u_parse (
    .byte_in          (s1_byte_r),
    .command_max_len  (cmd_max_r),
    .argument_max_len (arg_max_r),
    .state_cur        (state_r),
    .state_nxt        (state_nxt),
    .result           (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_byte;
    end
  end

  // Parse state moves on once per parsed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Length limits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_max_r <= clt_pkg::COMMAND_MAX_LEN_RST;
      arg_max_r <= clt_pkg::ARGUMENT_MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clt_pkg::REG_COMMAND_MAX_LEN:  cmd_max_r <= cfg_data;
        clt_pkg::REG_ARGUMENT_MAX_LEN: arg_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result register: load on a result, clear once transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_r.kind;
  assign out_field_id    = out_r.field_id;
  assign out_char_pos    = out_r.char_pos;
  assign out_char_value  = out_r.char_value;
  assign out_line_valid  = out_r.line_valid;

endmodule

// ----- rtl/core/clt_checker.sv -----
// Port-level checker for the command line tokenizer, bound to the top level.
// Depends on command_line_tokenizer_macros.svh and clt_pkg.
`include "command_line_tokenizer_macros.svh"

module clt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_result_kind,
  input logic [1:0] out_field_id,
  input logic [7:0] out_char_pos,
  input logic [7:0] out_char_value,
  input logic       out_line_valid
);

  `CLT_ASSERT_MSG(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_result_kind) && $stable(out_field_id) && $stable(out_char_pos) && $stable(out_char_value) && $stable(out_line_valid), "stalled result changed")
  `CLT_ASSERT(a_valid_only_eol, out_valid && out_line_valid |-> out_result_kind == clt_pkg::KIND_EOL)
  `CLT_ASSERT(a_eol_zero, out_valid && out_result_kind == clt_pkg::KIND_EOL |-> out_field_id == 2'd0 && out_char_pos == 8'd0 && out_char_value == 8'd0)
  `CLT_ASSERT(a_char_print, out_valid && out_result_kind == clt_pkg::KIND_CHAR |-> out_char_value >= clt_pkg::BYTE_SPACE && out_char_value <= clt_pkg::BYTE_TILDE && out_field_id != clt_pkg::MODE_INVALID)

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_kind (out_result_kind),
  .out_field_id    (out_field_id),
  .out_char_pos    (out_char_pos),
  .out_char_value  (out_char_value),
  .out_line_valid  (out_line_valid)
);

// ----- verif/tb_command_line_tokenizer.sv -----
// Self-checking testbench for command_line_tokenizer: directed and random
// command lines, randomly stalled on both channels, under several length limits.
// Depends on clt_pkg and the command_line_tokenizer RTL.
module tb_command_line_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import clt_pkg::*;

  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          DRAIN_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          PHASE_BYTES   = 80;
  localparam int          NUM_PHASES    = 7;
  localparam logic [7:0]  REG_INDEX_TOP = 8'hFF;

  // One result as it should leave the block
  typedef struct packed {
    logic       kind;
    logic [1:0] field_id;
    logic [7:0] char_pos;
    logic [7:0] char_value;
    logic       line_valid;
  } token_t;

  // Block ports, the driven ones known from time zero
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_result_kind;
  logic [1:0] out_field_id;
  logic [7:0] out_char_pos;
  logic [7:0] out_char_value;
  logic       out_line_valid;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_data  = 8'h00;

  // Bytes waiting for the driver and tokens waiting for the monitor
  logic [7:0] pending_bytes [$];
  token_t     expected_tokens [$];

  // Shadow of the parser: length limits and line state, reset values
  logic [7:0] lim_cmd  = COMMAND_MAX_LEN_RST;
  logic [7:0] lim_arg  = ARGUMENT_MAX_LEN_RST;
  logic [1:0] tok_mode = MODE_COMMAND;
  logic       tok_cr   = 1'b0;
  logic [7:0] tok_fill = 8'h00;

  int errors       = 0;
  int cycle_count  = 0;
  int bytes_sent   = 0;
  int chars_seen   = 0;
  int lines_seen   = 0;
  int settings_run = 1;
  int send_gap     = 0;
  int stall_left   = 0;
  bit send_calm    = 1'b0;
  bit recv_calm    = 1'b0;

  command_line_tokenizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_field_id    (out_field_id),
    .out_char_pos    (out_char_pos),
    .out_char_value  (out_char_value),
    .out_line_valid  (out_line_valid),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 20 ns period: high half, low half
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Print one line per fault and count it; the run carries on
  task automatic report_fault(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Back to command word mode with an empty field
  function automatic void restart_line();
    tok_mode = MODE_COMMAND;
    tok_cr   = 1'b0;
    tok_fill = 8'h00;
  endfunction

  // Advance the shadow parser by one accepted byte and queue the token it yields
  function automatic void tokenize_byte(input logic [7:0] b);
    token_t     t;
    logic [7:0] lim;
    t = '0;
    // CR seen on a live line: LF closes it cleanly, anything else spoils it
    if (tok_mode != MODE_INVALID && tok_cr) begin
      if (b == BYTE_LF) begin
        restart_line();
        t.kind       = KIND_EOL;
        t.line_valid = 1'b1;
        expected_tokens.push_back(t);
        return;
      end
      tok_mode = MODE_INVALID;
    end
    // Spoilt line: drop everything, watch only for CR LF
    if (tok_mode == MODE_INVALID) begin
      if (b == BYTE_CR) begin
        tok_cr = 1'b1;
      end else if (b == BYTE_LF && tok_cr) begin
        restart_line();
        t.kind = KIND_EOL;
        expected_tokens.push_back(t);
      end else begin
        tok_cr = 1'b0;
      end
      return;
    end
    // Space moves on a field; a third one spoils the line
    if (b == BYTE_SPACE) begin
      tok_mode = (tok_mode == MODE_ARG2) ? MODE_INVALID : tok_mode + 2'd1;
      tok_fill = 8'h00;
      return;
    end
    if (b == BYTE_CR) begin
      tok_cr = 1'b1;
      return;
    end
    // Full field or non-printable byte: spoil the line and drop the byte
    lim = (tok_mode == MODE_COMMAND) ? lim_cmd : lim_arg;
    if (tok_fill >= lim || b < BYTE_SPACE || b > BYTE_TILDE) begin
      tok_mode = MODE_INVALID;
      tok_cr   = 1'b0;
      return;
    end
    t.kind       = KIND_CHAR;
    t.field_id   = tok_mode;
    t.char_pos   = tok_fill;
    t.char_value = b;
    expected_tokens.push_back(t);
    tok_fill = tok_fill + 8'd1;
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [7:0] pick_printable();
    return 8'($urandom_range(BYTE_SPACE + 1, BYTE_TILDE));
  endfunction

  // Field length: mostly short, sometimes exactly full, sometimes one over
  function automatic int pick_len(input int lim);
    int r;
    int rim_pct;
    r       = $urandom_range(0, 99);
    rim_pct = (lim > 16) ? 1 : 5;
    if (r < rim_pct) return lim;
    if (r < 2 * rim_pct) return lim + 1;
    return $urandom_range(0, (lim < 6) ? lim : 6);
  endfunction

  // Queue one command line: well formed with random content, or broken in one way
  function automatic void queue_line(input int cmd_lim, input int arg_lim);
    int flavour;
    int nf;
    int len;
    flavour = $urandom_range(0, 99);
    nf      = $urandom_range(1, 3);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) pending_bytes.push_back(BYTE_SPACE);
      len = pick_len((f == 0) ? cmd_lim : arg_lim);
      for (int k = 0; k < len; k++) pending_bytes.push_back(pick_printable());
    end
    if (flavour < 65) begin
      // clean line, nothing added
    end else if (flavour < 72) begin
      // control byte or byte above the printable range
      if ($urandom_range(0, 1) == 0) pending_bytes.push_back(8'($urandom_range(0, 31)));
      else pending_bytes.push_back(8'($urandom_range(BYTE_TILDE + 1, 255)));
    end else if (flavour < 78) begin
      // one space too many, then a character
      for (int k = 0; k < 4 - nf; k++) pending_bytes.push_back(BYTE_SPACE);
      pending_bytes.push_back(pick_printable());
    end else if (flavour < 85) begin
      // CR not followed by LF
      pending_bytes.push_back(BYTE_CR);
      pending_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (flavour < 93) begin
      // raw noise, any byte at all
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) pending_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (nf < 3) begin
      // trailing space: next field stays empty
      pending_bytes.push_back(BYTE_SPACE);
    end
    pending_bytes.push_back(BYTE_CR);
    pending_bytes.push_back(BYTE_LF);
  endfunction

  // Write one length register over the configuration channel; track it on transfer
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_COMMAND_MAX_LEN) lim_cmd = val;
    else if (idx == REG_ARGUMENT_MAX_LEN) lim_arg = val;
  endtask

  // Hold until every byte is in and every token out, then let the pipe settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_tokens.size() != 0) begin
      report_fault($sformatf("%0d expected results never arrived", expected_tokens.size()));
      expected_tokens.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: offer the next pending byte, keep it steady while stalled, and
  // predict on every transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_byte(in_byte);
        bytes_sent++;
      end
      // Only a free or just-moved slot may change
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_byte  <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Drift in and out of stretches with no idling at all
      if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
    end
  end

  // Monitor: check each result transfer against the oldest expectation,
  // and stall the result channel at random
  always @(posedge clk) begin : monitor
    token_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (out_result_kind === KIND_EOL) lines_seen++;
        else chars_seen++;
        if (expected_tokens.size() == 0) begin
          report_fault($sformatf("unexpected result kind %0b field %0d pos %0d char %h",
                                 out_result_kind, out_field_id, out_char_pos,
                                 out_char_value));
        end else begin
          want = expected_tokens.pop_front();
          if (out_result_kind !== want.kind)
            report_fault($sformatf("result_kind %0b, expected %0b",
                                   out_result_kind, want.kind));
          if (out_field_id !== want.field_id)
            report_fault($sformatf("field_id %0d, expected %0d",
                                   out_field_id, want.field_id));
          if (out_char_pos !== want.char_pos)
            report_fault($sformatf("char_pos %0d, expected %0d",
                                   out_char_pos, want.char_pos));
          if (out_char_value !== want.char_value)
            report_fault($sformatf("char_value %h, expected %h",
                                   out_char_value, want.char_value));
          if (out_line_valid !== want.line_valid)
            report_fault($sformatf("line_valid %0b, expected %0b",
                                   out_line_valid, want.line_valid));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(recv_calm);
      end
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
    end
  end

  // Watchdog: give up well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: directed lines at the reset limits, then random lines under a
  // sequence of length settings, the registers written only while idle
  initial begin : stimulus
    int c;
    int a;
    int base;
    c = COMMAND_MAX_LEN_RST;
    a = ARGUMENT_MAX_LEN_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    pending_bytes = '{
      // all three fields, edge characters of the printable range
      BYTE_TILDE, 8'h21, BYTE_SPACE, 8'h41, BYTE_SPACE, 8'h42, BYTE_CR, BYTE_LF,
      // empty line
      BYTE_CR, BYTE_LF,
      // third space spoils the line
      BYTE_SPACE, BYTE_SPACE, BYTE_SPACE, BYTE_CR, BYTE_LF,
      // non-printable bytes, then CR CR LF still closes the line
      8'h7F, 8'h00, BYTE_CR, BYTE_CR, BYTE_LF,
      // lone LF, top byte, then the close
      BYTE_LF, 8'hFF, 8'h41, BYTE_CR, BYTE_LF,
      // CR followed by a character
      8'h41, BYTE_CR, 8'h42, BYTE_CR, BYTE_LF
    };

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin c = COMMAND_MAX_LEN_RST; a = ARGUMENT_MAX_LEN_RST; end
        1: begin c = 1;   a = 1;   end
        2: begin c = 255; a = 255; end
        3: begin c = 255; a = 1;   end
        4: begin c = 1;   a = 255; end
        5: begin c = $urandom_range(2, 12);  a = $urandom_range(2, 12);  end
        default: begin c = $urandom_range(1, 255); a = $urandom_range(1, 255); end
      endcase
      if (p > 0) begin
        wait_idle();
        // Stray index first: must leave both limits alone
        write_reg((p == 1) ? REG_INDEX_TOP : 8'($urandom_range(2, 255)),
                  8'($urandom_range(0, 255)));
        write_reg(REG_COMMAND_MAX_LEN, 8'(c));
        write_reg(REG_ARGUMENT_MAX_LEN, 8'(a));
        settings_run++;
      end
      // Widest command word: fill to 255, then one byte over
      if (p == 2) begin
        for (int k = 0; k < 256; k++) pending_bytes.push_back(pick_printable());
        pending_bytes.push_back(BYTE_CR);
        pending_bytes.push_back(BYTE_LF);
      end
      base = pending_bytes.size();
      while (pending_bytes.size() - base < PHASE_BYTES) queue_line(c, a);
    end

    wait_idle();
    $display("Sent %0d bytes under %0d length settings", bytes_sent, settings_run);
    $display("Checked %0d field characters and %0d line ends", chars_seen, lines_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/clt_pkg.sv
rtl/core/clt_parse.sv
rtl/core/command_line_tokenizer.sv
rtl/core/clt_checker.sv
verif/tb_command_line_tokenizer.sv
